// File: sv/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// shared types, codes and widths for the text console cursor engine
// ----------------------------------------------------------------------------
package tcce_pkg;

    // default geometry of the cell buffer
    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 48;

    // field widths
    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int BG_W     = 4;
    localparam int TCOL_W   = 7;
    localparam int TROW_W   = 6;
    localparam int ADDR_O_W = 12;
    localparam int CELL_W   = 16;
    localparam int LIMIT_W  = 6;

    localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd48;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [3:0] ATTR_FG_WHITE = 4'hF;
    localparam int TAB_STEP = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_SET   = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCR_N,
        ST_SCR_ADDR,
        ST_COPY,
        ST_FILL,
        ST_READ,
        ST_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic do_capture;
        logic do_exec;
        logic do_scr_n;
        logic do_scr_addr;
        logic do_copy;
        logic do_fill;
        logic do_read;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_scroll;
        logic is_clear;
        logic is_read;
        logic copy_done;
        logic fill_last;
    } t_dp_stat;

endpackage

// File: sv/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl
// command sequencer: init sweep, execute, scroll copy and fill, read, done
// ----------------------------------------------------------------------------
module tcce_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  tcce_pkg::t_dp_stat  i_stat,
    output logic                busy,
    output logic                o_done,
    output tcce_pkg::t_dp_cmd   o_cmd
);
    import tcce_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_done  = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                o_cmd.do_fill = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.do_capture = 1'b1;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.do_exec = 1'b1;
                if (i_stat.need_scroll) begin
                    n_state = ST_SCR_N;
                end else if (i_stat.is_clear) begin
                    n_state = ST_FILL;
                end else if (i_stat.is_read) begin
                    n_state = ST_READ;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SCR_N: begin
                o_cmd.do_scr_n = 1'b1;
                n_state = ST_SCR_ADDR;
            end
            ST_SCR_ADDR: begin
                o_cmd.do_scr_addr = 1'b1;
                n_state = ST_COPY;
            end
            ST_COPY: begin
                o_cmd.do_copy = 1'b1;
                if (i_stat.copy_done) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                o_cmd.do_fill = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_READ: begin
                o_cmd.do_read = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

endmodule

// File: sv/tcce_dp.sv
// ----------------------------------------------------------------------------
// tcce_dp
// cursor, cell memory, scroll copy/fill pointer and result registers
// ----------------------------------------------------------------------------
module tcce_dp #(
    parameter int COLS = tcce_pkg::COLS_DEF,
    parameter int ROWS = tcce_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tcce_pkg::t_dp_cmd                 i_cmd,
    output tcce_pkg::t_dp_stat                o_stat,
    input  logic                              i_cfg_we,
    input  logic [tcce_pkg::LIMIT_W-1:0]      i_cfg_data,
    input  logic [tcce_pkg::CMD_W-1:0]        i_command,
    input  logic [tcce_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcce_pkg::ATTR_W-1:0]       i_attribute,
    input  logic [tcce_pkg::BG_W-1:0]         i_back_color,
    input  logic [tcce_pkg::TCOL_W-1:0]       i_target_col,
    input  logic [tcce_pkg::TROW_W-1:0]       i_target_row,
    output logic [tcce_pkg::TCOL_W-1:0]       o_cursor_col,
    output logic [tcce_pkg::TROW_W-1:0]       o_cursor_row,
    output logic                              o_cell_written,
    output logic [tcce_pkg::ADDR_O_W-1:0]     o_cell_address,
    output logic [tcce_pkg::CELL_W-1:0]       o_cell_value,
    output logic                              o_redraw,
    output logic [tcce_pkg::CELL_W-1:0]       o_read_value
);
    import tcce_pkg::*;

    localparam int TOTAL = COLS * ROWS;
    localparam int AW    = $clog2(TOTAL);
    localparam int CIW   = $clog2(COLS);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int TW    = $clog2(COLS + TAB_STEP);

    localparam logic [AW-1:0]  COLS_A   = AW'(COLS);
    localparam logic [AW:0]    COLS_E   = (AW+1)'(COLS);
    localparam logic [AW:0]    TOTAL_E  = (AW+1)'(TOTAL);
    localparam logic [CIW-1:0] COL_LAST = CIW'(COLS - 1);
    localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
    localparam logic [RW-1:0]  ROWS_R   = RW'(ROWS);
    localparam logic [TW-1:0]  COLS_T   = TW'(COLS);
    localparam logic [TW-1:0]  TAB_MASK = ~TW'(TAB_STEP - 1);
    localparam logic [7:0]     COLS_8   = 8'(COLS);
    localparam logic [6:0]     ROWS_7   = 7'(ROWS);

    // captured item
    t_cmd              r_cmd;
    logic [CHAR_W-1:0] r_char;
    logic [ATTR_W-1:0] r_attr;
    logic [BG_W-1:0]   r_bg;
    logic [TCOL_W-1:0] r_tc;
    logic [TROW_W-1:0] r_tr;

    // cursor and config
    logic [CIW-1:0]     r_col;
    logic [RW-1:0]      r_row;
    logic [LIMIT_W-1:0] r_limit;

    // scroll / fill engine
    logic [RW-1:0]     r_shift;
    logic [RW-1:0]     r_keep;
    logic [AW-1:0]     r_copy_len;
    logic [AW-1:0]     r_src_off;
    logic [AW:0]       r_fill_end;
    logic [CELL_W-1:0] r_fill_val;
    logic [AW-1:0]     r_ptr;
    logic [AW-1:0]     r_wptr;
    logic              r_pend;

    // results
    logic              r_res_wr;
    logic [AW-1:0]     r_res_addr;
    logic [CELL_W-1:0] r_res_val;
    logic              r_redraw;
    logic [CELL_W-1:0] r_read_value;

    // cell memory
    logic [CELL_W-1:0] mem [TOTAL];
    logic [CELL_W-1:0] r_q;

    logic [RW-1:0]     se;
    logic [RW-1:0]     row_inc;
    logic [RW-1:0]     diff;
    logic [TW-1:0]     tab_sum;
    logic [CIW-1:0]    n_col;
    logic [RW-1:0]     n_row;
    logic [CIW-1:0]    wcol;
    logic [RW-1:0]     wrow;
    logic [CHAR_W-1:0] wchar;
    logic              wr;
    logic              adv;
    logic [AW-1:0]     exec_addr;
    logic [AW-1:0]     cell_addr;
    logic              tgt_ok;
    logic [CIW-1:0]    set_col;
    logic [RW-1:0]     set_row;
    logic              copy_go;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [CELL_W-1:0] wdata;
    logic [AW-1:0]     raddr;

    // effective window rows, zero acts as one and values above ROWS are capped to ROWS
    always_comb begin
        if (r_limit == '0) begin
            se = RW'(1);
        end else if (7'(r_limit) > ROWS_7) begin
            se = ROWS_R;
        end else begin
            se = RW'(r_limit);
        end
    end

    assign row_inc = r_row + RW'(1);
    assign diff    = r_row - se + RW'(1);

    // put character decode
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        wcol    = r_col;
        wrow    = r_row;
        wchar   = r_char;
        wr      = 1'b0;
        adv     = 1'b0;
        tab_sum = (TW'(r_col) + TW'(TAB_STEP)) & TAB_MASK;
        case (r_char)
            CH_BS: begin
                if (r_col != '0) begin
                    wcol  = r_col - CIW'(1);
                    wchar = CH_SPACE;
                    wr    = 1'b1;
                    n_col = wcol;
                end else if (r_row != '0) begin
                    wcol  = COL_LAST;
                    wrow  = r_row - RW'(1);
                    wchar = CH_SPACE;
                    wr    = 1'b1;
                    n_col = wcol;
                    n_row = wrow;
                end
            end
            CH_TAB: begin
                if (tab_sum >= COLS_T) begin
                    n_col = '0;
                    n_row = row_inc;
                    adv   = 1'b1;
                end else begin
                    n_col = CIW'(tab_sum);
                end
            end
            CH_CR: begin
                n_col = '0;
            end
            CH_LF: begin
                n_col = '0;
                n_row = row_inc;
                adv   = 1'b1;
            end
            CH_NUL: begin
                n_col = r_col;
            end
            default: begin
                wr = 1'b1;
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    n_row = row_inc;
                    adv   = 1'b1;
                end else begin
                    n_col = r_col + CIW'(1);
                end
            end
        endcase
    end

    assign exec_addr = AW'(wrow) * COLS_A + AW'(wcol);
    assign cell_addr = AW'(r_tr) * COLS_A + AW'(r_tc);
    assign tgt_ok    = (8'(r_tc) < COLS_8) && (7'(r_tr) < ROWS_7);
    assign set_col   = (8'(r_tc) < COLS_8) ? CIW'(r_tc) : COL_LAST;
    assign set_row   = (7'(r_tr) < ROWS_7) ? RW'(r_tr) : ROW_LAST;
    assign copy_go   = r_ptr < r_copy_len;

    assign o_stat.need_scroll = (r_cmd == CMD_PUT) && adv && (row_inc >= se);
    assign o_stat.is_clear    = (r_cmd == CMD_CLEAR);
    assign o_stat.is_read     = (r_cmd == CMD_READ);
    assign o_stat.copy_done   = !copy_go && !r_pend;
    assign o_stat.fill_last   = ({1'b0, r_ptr} == (r_fill_end - (AW+1)'(1)));

    // memory port muxing
    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = r_fill_val;
        if (i_cmd.do_exec && (r_cmd == CMD_PUT) && wr) begin
            we    = 1'b1;
            waddr = exec_addr;
            wdata = {r_attr, wchar};
        end else if (i_cmd.do_copy && r_pend) begin
            we    = 1'b1;
            waddr = r_wptr;
            wdata = r_q;
        end else if (i_cmd.do_fill) begin
            we    = 1'b1;
        end
    end

    assign raddr = i_cmd.do_copy ? (r_ptr + r_src_off) : cell_addr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_q <= mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_limit    <= LIMIT_RST;
            r_ptr      <= '0;
            r_fill_end <= TOTAL_E;
            r_fill_val <= '0;
            r_pend     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.do_exec) begin
                case (r_cmd)
                    CMD_PUT: begin
                        r_col <= n_col;
                        r_row <= n_row;
                    end
                    CMD_CLEAR: begin
                        r_col      <= '0;
                        r_row      <= '0;
                        r_ptr      <= '0;
                        r_fill_end <= TOTAL_E;
                        r_fill_val <= {r_bg, ATTR_FG_WHITE, CH_SPACE};
                    end
                    CMD_SET: begin
                        r_col <= set_col;
                        r_row <= set_row;
                    end
                    default: begin
                        r_col <= r_col;
                    end
                endcase
            end
            if (i_cmd.do_scr_addr) begin
                r_row      <= se - RW'(1);
                r_ptr      <= '0;
                r_fill_end <= (AW+1)'(se) * COLS_E;
                r_fill_val <= {r_attr, CH_NUL};
            end
            if (i_cmd.do_copy) begin
                r_pend <= copy_go;
                if (copy_go) begin
                    r_ptr <= r_ptr + AW'(1);
                end
            end
            if (i_cmd.do_fill) begin
                r_ptr <= r_ptr + AW'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_capture) begin
            r_cmd  <= t_cmd'(i_command);
            r_char <= i_char_code;
            r_attr <= i_attribute;
            r_bg   <= i_back_color;
            r_tc   <= i_target_col;
            r_tr   <= i_target_row;
        end
        if (i_cmd.do_exec) begin
            r_res_wr     <= (r_cmd == CMD_PUT) && wr;
            r_res_addr   <= ((r_cmd == CMD_PUT) && wr) ? exec_addr : '0;
            r_res_val    <= ((r_cmd == CMD_PUT) && wr) ? {r_attr, wchar} : '0;
            r_redraw     <= (r_cmd == CMD_CLEAR);
            r_read_value <= '0;
        end
        if (i_cmd.do_scr_n) begin
            r_shift <= (diff > se) ? se : diff;
            r_keep  <= se - ((diff > se) ? se : diff);
        end
        if (i_cmd.do_scr_addr) begin
            r_copy_len <= AW'(r_keep) * COLS_A;
            r_src_off  <= AW'(r_shift) * COLS_A;
            r_redraw   <= 1'b1;
        end
        if (i_cmd.do_copy) begin
            r_wptr <= r_ptr;
        end
        if (i_cmd.do_read) begin
            r_read_value <= tgt_ok ? r_q : '0;
        end
    end

    assign o_cursor_col   = TCOL_W'(r_col);
    assign o_cursor_row   = TROW_W'(r_row);
    assign o_cell_written = r_res_wr;
    assign o_cell_address = ADDR_O_W'(r_res_addr);
    assign o_cell_value   = r_res_val;
    assign o_redraw       = r_redraw;
    assign o_read_value   = r_read_value;

endmodule

// File: sv/text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// text_console_cursor_engine_core
// teletype console over a character/attribute cell buffer with cursor control
// ----------------------------------------------------------------------------
//
//  channel   handshake                      payload
//  -------   -----------------------------  ----------------------------------
//  command   start / busy (taken: start     i_command, i_char_code,
//            high while busy low)           i_attribute, i_back_color,
//                                           i_target_col, i_target_row
//  result    o_done (one-cycle strobe)      o_cursor_col, o_cursor_row,
//                                           o_cell_written, o_cell_address,
//                                           o_cell_value, o_redraw,
//                                           o_read_value
//  config    i_cfg_valid / o_cfg_ready      i_cfg_data (scroll limit)
//
//  put char, set cursor, read cell: each item is captured, executed and
//  reported with o_done before busy drops and the next item is taken
//  scroll: bound by the single write port of the cell memory (copy one word
//  per cycle, then blank the vacated rows)
//  clear: one cell written per cycle
//  after reset a clearing sweep of all ROWS*COLS cells zeroes
//  the buffer with busy high; config writes are taken at any time
//  results cannot be stalled: each item's result is shown once with o_done
//
module text_console_cursor_engine_core #(
    parameter int COLS = tcce_pkg::COLS_DEF,
    parameter int ROWS = tcce_pkg::ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [tcce_pkg::CMD_W-1:0]        i_command,
    input  logic [tcce_pkg::CHAR_W-1:0]       i_char_code,
    input  logic [tcce_pkg::ATTR_W-1:0]       i_attribute,
    input  logic [tcce_pkg::BG_W-1:0]         i_back_color,
    input  logic [tcce_pkg::TCOL_W-1:0]       i_target_col,
    input  logic [tcce_pkg::TROW_W-1:0]       i_target_row,
    // result channel
    output logic                              o_done,
    output logic [tcce_pkg::TCOL_W-1:0]       o_cursor_col,
    output logic [tcce_pkg::TROW_W-1:0]       o_cursor_row,
    output logic                              o_cell_written,
    output logic [tcce_pkg::ADDR_O_W-1:0]     o_cell_address,
    output logic [tcce_pkg::CELL_W-1:0]       o_cell_value,
    output logic                              o_redraw,
    output logic [tcce_pkg::CELL_W-1:0]       o_read_value,
    // config channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcce_pkg::LIMIT_W-1:0]      i_cfg_data
);
    import tcce_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // the scroll limit register is separate from the sequencer, so a write
    // can always be taken
    assign o_cfg_ready = 1'b1;

    // sequencer: init sweep, execute, scroll copy/fill, read, done strobe
    tcce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (dp_stat),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd)
    );

    // cursor, cell memory and result registers
    tcce_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .i_back_color   (i_back_color),
        .i_target_col   (i_target_col),
        .i_target_row   (i_target_row),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_cell_written (o_cell_written),
        .o_cell_address (o_cell_address),
        .o_cell_value   (o_cell_value),
        .o_redraw       (o_redraw),
        .o_read_value   (o_read_value)
    );

endmodule

// File: sim/tb_text_console_cursor_engine_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_cursor_engine_core
// self-checking bench for the teletype console cursor engine
// ----------------------------------------------------------------------------
// a shadow copy of the cell buffer, cursor and scroll limit predicts the
// report for every command the engine takes; each o_done report is compared
// field by field with the oldest prediction. a short directed run covers the
// control codes, wrap, clamp, scroll and out-of-range reads, then random
// phases run under a range of scroll limits, the extremes among them
// ----------------------------------------------------------------------------
module tb_text_console_cursor_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    import tcce_pkg::*;

    localparam int NCOLS         = COLS_DEF;
    localparam int NROWS         = ROWS_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 88;
    // worst case: ~725 items each paying a full-window scroll or a clear
    // plus sender gaps and the sweep after reset, taken ~4x
    localparam int unsigned MAX_CYCLES = 12_000_000;

    // one report of the engine, at port widths
    typedef struct packed {
        logic [TCOL_W-1:0]   col;
        logic [TROW_W-1:0]   row;
        logic                written;
        logic [ADDR_O_W-1:0] addr;
        logic [CELL_W-1:0]   value;
        logic                redraw;
        logic [CELL_W-1:0]   rd;
    } t_report;

    // shadow console: predicts reports and checks the ones that come back
    class console_shadow;
        logic [CELL_W-1:0] screen [NCOLS*NROWS];
        int unsigned       pos_col;
        int unsigned       pos_row;
        int unsigned       window_limit;
        t_report           expected_reports [$];
        int unsigned       failures;

        function new();
            foreach (screen[i]) screen[i] = '0;
            pos_col      = 0;
            pos_row      = 0;
            window_limit = 32'(LIMIT_RST);
            failures     = 0;
        endfunction

        function int unsigned window_rows();
            int unsigned se;
            se = window_limit;
            if (se < 1) se = 1;
            if (se > NROWS) se = NROWS;
            return se;
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        // shift the window up once the cursor has left it, blank the vacated rows
        function bit scroll_up(logic [ATTR_W-1:0] attr);
            int unsigned se;
            int unsigned n;
            se = window_rows();
            if (pos_row < se) return 1'b0;
            n = pos_row - se + 1;
            if (n > se) n = se;
            for (int unsigned r = 0; r + n < se; r++)
                for (int unsigned c = 0; c < NCOLS; c++)
                    screen[r*NCOLS + c] = screen[(r+n)*NCOLS + c];
            for (int unsigned r = se - n; r < se; r++)
                for (int unsigned c = 0; c < NCOLS; c++)
                    screen[r*NCOLS + c] = {attr, CH_NUL};
            pos_row = se - 1;
            return 1'b1;
        endfunction

        function void note_command(t_cmd cmd, logic [CHAR_W-1:0] ch,
                                   logic [ATTR_W-1:0] attr, logic [BG_W-1:0] bg,
                                   logic [TCOL_W-1:0] tcol, logic [TROW_W-1:0] trow);
            t_report     r;
            int unsigned a;
            r = '0;
            case (cmd)
                CMD_PUT: begin
                    if (ch == CH_BS) begin
                        if (pos_col > 0) begin
                            pos_col--;
                            r.written = 1'b1;
                        end else if (pos_row > 0) begin
                            pos_col = NCOLS - 1;
                            pos_row--;
                            r.written = 1'b1;
                        end
                        if (r.written) begin
                            a = pos_row*NCOLS + pos_col;
                            r.addr  = a[ADDR_O_W-1:0];
                            r.value = {attr, CH_SPACE};
                            screen[a] = r.value;
                        end
                    end else if (ch == CH_TAB) begin
                        pos_col = (pos_col + TAB_STEP) & ~(TAB_STEP - 1);
                        if (pos_col >= NCOLS) begin
                            pos_col = 0;
                            pos_row++;
                            r.redraw = scroll_up(attr);
                        end
                    end else if (ch == CH_CR) begin
                        pos_col = 0;
                    end else if (ch == CH_LF) begin
                        pos_row++;
                        r.redraw = scroll_up(attr);
                        pos_col = 0;
                    end else if (ch != CH_NUL) begin
                        a = pos_row*NCOLS + pos_col;
                        r.addr    = a[ADDR_O_W-1:0];
                        r.value   = {attr, ch};
                        r.written = 1'b1;
                        screen[a] = r.value;
                        pos_col++;
                        if (pos_col >= NCOLS) begin
                            pos_col = 0;
                            pos_row++;
                            r.redraw = scroll_up(attr);
                        end
                    end
                end
                CMD_CLEAR: begin
                    foreach (screen[i]) screen[i] = {bg, ATTR_FG_WHITE, CH_SPACE};
                    pos_col  = 0;
                    pos_row  = 0;
                    r.redraw = 1'b1;
                end
                CMD_SET: begin
                    pos_col = (tcol < NCOLS) ? tcol : NCOLS - 1;
                    pos_row = (trow < NROWS) ? trow : NROWS - 1;
                end
                default: begin
                    if (tcol < NCOLS && trow < NROWS)
                        r.rd = screen[trow*NCOLS + tcol];
                end
            endcase
            r.col = pos_col[TCOL_W-1:0];
            r.row = pos_row[TROW_W-1:0];
            expected_reports.push_back(r);
        endfunction

        function void compare_field(string name, logic [CELL_W-1:0] want,
                                    logic [CELL_W-1:0] seen);
            if (seen !== want) begin
                $error("%s: expected %0h, got %0h", name, want, seen);
                failures++;
            end
        endfunction

        function void check_report(t_report seen);
            t_report want;
            if (expected_reports.size() == 0) begin
                $error("report with no command outstanding");
                failures++;
                return;
            end
            want = expected_reports.pop_front();
            compare_field("cursor_col",   CELL_W'(want.col),     CELL_W'(seen.col));
            compare_field("cursor_row",   CELL_W'(want.row),     CELL_W'(seen.row));
            compare_field("cell_written", CELL_W'(want.written), CELL_W'(seen.written));
            compare_field("cell_address", CELL_W'(want.addr),    CELL_W'(seen.addr));
            compare_field("cell_value",   want.value,            seen.value);
            compare_field("redraw",       CELL_W'(want.redraw),  CELL_W'(seen.redraw));
            compare_field("read_value",   want.rd,               seen.rd);
        endfunction
    endclass

    // clock, reset and block ports, all known from time zero
    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                start        = 1'b0;
    logic                busy;
    logic [CMD_W-1:0]    i_command    = '0;
    logic [CHAR_W-1:0]   i_char_code  = '0;
    logic [ATTR_W-1:0]   i_attribute  = '0;
    logic [BG_W-1:0]     i_back_color = '0;
    logic [TCOL_W-1:0]   i_target_col = '0;
    logic [TROW_W-1:0]   i_target_row = '0;
    logic                o_done;
    logic [TCOL_W-1:0]   o_cursor_col;
    logic [TROW_W-1:0]   o_cursor_row;
    logic                o_cell_written;
    logic [ADDR_O_W-1:0] o_cell_address;
    logic [CELL_W-1:0]   o_cell_value;
    logic                o_redraw;
    logic [CELL_W-1:0]   o_read_value;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_data   = '0;

    console_shadow shadow;
    bit            steady_sender = 1'b0;   // suppresses sender gaps for one phase
    int unsigned   cycle_count   = 0;

    text_console_cursor_engine_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_char_code    (i_char_code),
        .i_attribute    (i_attribute),
        .i_back_color   (i_back_color),
        .i_target_col   (i_target_col),
        .i_target_row   (i_target_row),
        .o_done         (o_done),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_cell_written (o_cell_written),
        .o_cell_address (o_cell_address),
        .o_cell_value   (o_cell_value),
        .o_redraw       (o_redraw),
        .o_read_value   (o_read_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // sample at the rising edge: inputs only move on the falling edge, so
    // start and the payload are stable here and busy/o_done show pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // the report goes first so a same-edge accept cannot jump ahead
            if (o_done)
                shadow.check_report({o_cursor_col, o_cursor_row, o_cell_written,
                                     o_cell_address, o_cell_value, o_redraw,
                                     o_read_value});
            if (start && !busy)
                shadow.note_command(t_cmd'(i_command), i_char_code, i_attribute,
                                    i_back_color, i_target_col, i_target_row);
        end
    end

    // watchdog, counted in clock cycles
    initial begin
        while (cycle_count < MAX_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("text_console_cursor_engine_core: mismatch");
        $finish;
    end

    // present one command and hold it until the engine takes it; entered and
    // left at a falling edge, start is left high so a back-to-back item never
    // sees a low pulse
    task automatic issue_command(input t_cmd cmd, input logic [CHAR_W-1:0] ch,
                                 input logic [ATTR_W-1:0] attr,
                                 input logic [BG_W-1:0] bg,
                                 input logic [TCOL_W-1:0] tcol,
                                 input logic [TROW_W-1:0] trow);
        if (!steady_sender) begin
            // random idle cycles, about 30 in 100
            while ($urandom_range(99) < 30) begin
                start = 1'b0;
                @(negedge i_clk);
            end
        end
        start        = 1'b1;
        i_command    = cmd;
        i_char_code  = ch;
        i_attribute  = attr;
        i_back_color = bg;
        i_target_col = tcol;
        i_target_row = trow;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop sending until every predicted report has come back
    task automatic drain_reports();
        start = 1'b0;
        while (shadow.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_scroll_limit(input logic [LIMIT_W-1:0] lim);
        i_cfg_valid = 1'b1;
        i_cfg_data  = lim;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        shadow.window_limit = 32'(lim);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // one random command: mostly characters, with cursor moves aimed at the
    // bottom of the window so scrolls come often, reads and rare clears
    task automatic random_command();
        int unsigned       pick;
        int unsigned       se;
        t_cmd              cmd;
        logic [CHAR_W-1:0] ch;
        logic [TCOL_W-1:0] tcol;
        logic [TROW_W-1:0] trow;
        pick = $urandom_range(99);
        se   = shadow.window_rows();
        ch   = CHAR_W'($urandom_range(255));
        tcol = TCOL_W'($urandom_range(127));
        trow = TROW_W'($urandom_range(63));
        if (pick < 72) begin
            cmd  = CMD_PUT;
            pick = $urandom_range(99);
            if (pick < 8)       ch = CH_LF;
            else if (pick < 12) ch = CH_CR;
            else if (pick < 18) ch = CH_BS;
            else if (pick < 24) ch = CH_TAB;
            else if (pick < 27) ch = CH_NUL;
        end else if (pick < 84) begin
            cmd  = CMD_SET;
            pick = $urandom_range(99);
            if (pick < 80) tcol = TCOL_W'($urandom_range(NCOLS - 1));
            pick = $urandom_range(99);
            if (pick < 30)      trow = TROW_W'(se - 1);   // next row advance scrolls
            else if (pick < 80) trow = TROW_W'($urandom_range(NROWS - 1));
        end else if (pick < 97) begin
            cmd = CMD_READ;
            if ($urandom_range(99) < 85) begin
                tcol = TCOL_W'($urandom_range(NCOLS - 1));
                trow = TROW_W'($urandom_range(NROWS - 1));
            end
        end else begin
            cmd = CMD_CLEAR;
        end
        issue_command(cmd, ch, ATTR_W'($urandom_range(255)), BG_W'($urandom_range(15)),
                      tcol, trow);
    endtask

    initial begin
        logic [LIMIT_W-1:0] phase_limits [8];
        phase_limits = '{6'd1, 6'd0, 6'd63, 6'd5, 6'd48, 6'd2, 6'd24, 6'd8};
        shadow = new();

        // synchronous reset
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part at the reset scroll limit (whole buffer is the window)
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd0,   6'd0);   // reset contents
        issue_command(CMD_PUT,   8'h41,  8'hFF, 4'h0, 7'd0,   6'd0);
        issue_command(CMD_PUT,   CH_NUL, 8'h12, 4'h0, 7'd0,   6'd0);   // ignored byte
        issue_command(CMD_PUT,   CH_BS,  8'h07, 4'h0, 7'd0,   6'd0);   // erase to the left
        issue_command(CMD_PUT,   CH_BS,  8'h07, 4'h0, 7'd0,   6'd0);   // home: no effect
        issue_command(CMD_PUT,   CH_TAB, 8'h00, 4'h0, 7'd0,   6'd0);
        issue_command(CMD_SET,   CH_NUL, 8'h00, 4'h0, 7'd79,  6'd0);
        issue_command(CMD_PUT,   8'h5A,  8'h00, 4'h0, 7'd0,   6'd0);   // last column wraps
        issue_command(CMD_PUT,   CH_CR,  8'h00, 4'h0, 7'd0,   6'd0);
        issue_command(CMD_SET,   CH_NUL, 8'h00, 4'h0, 7'd127, 6'd63);  // clamped
        issue_command(CMD_PUT,   8'hFF,  8'hA5, 4'h0, 7'd0,   6'd0);   // wrap into a scroll
        issue_command(CMD_PUT,   CH_BS,  8'h1E, 4'h0, 7'd0,   6'd0);   // back to previous row
        issue_command(CMD_SET,   CH_NUL, 8'h00, 4'h0, 7'd76,  6'd47);
        issue_command(CMD_PUT,   CH_TAB, 8'h3C, 4'h0, 7'd0,   6'd0);   // tab past the edge
        issue_command(CMD_PUT,   CH_LF,  8'h00, 4'h0, 7'd0,   6'd0);   // line feed scroll
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd79,  6'd45);
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd80,  6'd0);   // column out of range
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd0,   6'd48);  // row out of range
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd127, 6'd63);
        issue_command(CMD_CLEAR, CH_NUL, 8'h00, 4'hF, 7'd0,   6'd0);
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd79,  6'd47);
        issue_command(CMD_CLEAR, CH_NUL, 8'h00, 4'h0, 7'd0,   6'd0);
        issue_command(CMD_PUT,   8'h80,  8'h80, 4'h0, 7'd0,   6'd0);
        issue_command(CMD_READ,  CH_NUL, 8'h00, 4'h0, 7'd0,   6'd0);

        // random phases, each under its own scroll limit; zero acts as one and
        // anything above the buffer height is capped to it
        foreach (phase_limits[p]) begin
            drain_reports();
            write_scroll_limit(phase_limits[p]);
            steady_sender = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                random_command();
                if ($urandom_range(99) == 0) drain_reports();
            end
        end
        steady_sender = 1'b0;

        drain_reports();
        if (shadow.failures == 0 && shadow.pending() == 0)
            $display("text_console_cursor_engine_core: match");
        else
            $display("text_console_cursor_engine_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
sv/tcce_pkg.sv
sv/tcce_ctrl.sv
sv/tcce_dp.sv
sv/text_console_cursor_engine_core.sv
sim/tb_text_console_cursor_engine_core.sv
